### hw/rtl/sfpc_pkg.sv
// ----------------------------------------------------------------------------
// sfpc_pkg
// Shared constants, types and the check step for the framed packet checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpc_pkg;

    localparam int PACKET_BYTES_DEF = 11;
    localparam int POS_W            = 4;
    localparam int PAYLOAD_W        = 64;
    localparam int CHECK_W          = 16;

    localparam logic [7:0]         SYNC_BYTE  = 8'hFF;
    localparam logic [CHECK_W-1:0] CHECK_POLY = 16'h1021;

    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic                 check_ok;
        logic [CHECK_W-1:0]   received_check;
    } t_result;

    // One payload byte into the running check: shift, fold the top bit back
    // in through the polynomial, then mix in the byte pair.
    function automatic logic [CHECK_W-1:0] check_step(
        input logic [CHECK_W-1:0] chk,
        input logic [7:0]         prev,
        input logic [7:0]         cur
    );
        logic [CHECK_W-1:0] sh;
        sh = {chk[CHECK_W-2:0], 1'b0};
        if (chk[CHECK_W-1]) begin
            sh = sh ^ CHECK_POLY;
        end
        return sh ^ {prev, cur};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sfpc_if.sv
// ----------------------------------------------------------------------------
// sfpc_rx_if / sfpc_res_if
// Valid/ready channels: received bytes in, checked packets out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfpc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfpc_res_if;
    logic                           valid;
    logic                           ready;
    logic [sfpc_pkg::PAYLOAD_W-1:0] payload;
    logic                           check_ok;
    logic [sfpc_pkg::CHECK_W-1:0]   received_check;

    modport source (output valid, output payload, output check_ok,
                    output received_check, input ready);
    modport sink   (input valid, input payload, input check_ok,
                    input received_check, output ready);
endinterface

`default_nettype wire

### hw/rtl/sfpc_framer.sv
// ----------------------------------------------------------------------------
// sfpc_framer
// Sync hunt, byte position tracking, payload collection and running check.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpc_framer #(
    parameter int PACKET_BYTES = sfpc_pkg::PACKET_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    output logic                   o_emit,
    output sfpc_pkg::t_result      o_result
);

    localparam sfpc_pkg::t_pos POS_END  = sfpc_pkg::t_pos'(PACKET_BYTES);
    localparam sfpc_pkg::t_pos POS_DATA = sfpc_pkg::t_pos'(PACKET_BYTES - 3);
    localparam sfpc_pkg::t_pos POS_CHI  = sfpc_pkg::t_pos'(PACKET_BYTES - 2);

    sfpc_pkg::t_pos                  r_pos, n_pos;
    logic [sfpc_pkg::CHECK_W-1:0]    r_check;
    logic [7:0]                      r_prev;
    logic [sfpc_pkg::PAYLOAD_W-1:0]  r_payload;
    logic [7:0]                      r_chk_hi;

    logic hunt, is_data, is_chk_hi;
    logic [sfpc_pkg::CHECK_W-1:0] rx_check;

    assign hunt      = (r_pos == '0) || (r_pos >= POS_END);
    assign is_data   = !hunt && (r_pos <= POS_DATA);
    assign is_chk_hi = !hunt && (r_pos == POS_CHI);
    assign o_emit    = !hunt && !is_data && !is_chk_hi;

    assign rx_check = {r_chk_hi, i_byte};

    always_comb begin
        o_result.payload        = r_payload;
        o_result.check_ok       = (r_check == rx_check);
        o_result.received_check = rx_check;
    end

    always_comb begin
        n_pos = r_pos;
        if (hunt) begin
            n_pos = (i_byte == sfpc_pkg::SYNC_BYTE) ? sfpc_pkg::t_pos'(1) : '0;
        end else if (o_emit) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + sfpc_pkg::t_pos'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
        end
    end

    // datapath state: check, prev byte and payload cleared on sync before any use
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (hunt && (i_byte == sfpc_pkg::SYNC_BYTE)) begin
                r_check   <= '0;
                r_prev    <= '0;
                r_payload <= '0;
            end else if (is_data) begin
                r_check   <= sfpc_pkg::check_step(r_check, r_prev, i_byte);
                r_prev    <= i_byte;
                r_payload <= {r_payload[sfpc_pkg::PAYLOAD_W-9:0], i_byte};
            end
            if (is_chk_hi) begin
                r_chk_hi <= i_byte;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sync_framed_packet_checker.sv
// ----------------------------------------------------------------------------
// sync_framed_packet_checker
// Hunts for the sync byte, collects fixed-length packets, checks them.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Modport  Payload                                  Per transfer
//  i_rx     in   sink     rx_byte[7:0]                             one byte
//  o_res    out  source   payload[63:0], check_ok, received_check  one packet
//
// One byte per cycle sustained. A byte is held in the input register,
// then the framer updates position, payload and check in a single pass; the
// last check byte of a packet loads the result register.
// The last byte moves from the input register into the result register,
// which drives o_res.valid.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// framer to hunting. A stall on o_res holds the result; the input register
// still drains non-final bytes, so i_rx only stalls when a second packet end
// meets a full result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_framed_packet_checker #(
    parameter int PACKET_BYTES = sfpc_pkg::PACKET_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sfpc_rx_if.sink    i_rx,
    sfpc_res_if.source o_res
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // result register
    logic              r_out_valid;
    sfpc_pkg::t_result r_out;

    logic              emit;
    logic              step;
    logic              out_free;
    sfpc_pkg::t_result result;

    // Result slot is free if empty or being taken in this cycle.
    assign out_free = !r_out_valid || o_res.ready;

    // The held byte moves on unless it ends a packet and the slot is busy.
    assign step = r_in_valid && (!emit || out_free);

    assign i_rx.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    sfpc_framer #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.payload        = r_out.payload;
    assign o_res.check_ok       = r_out.check_ok;
    assign o_res.received_check = r_out.received_check;

endmodule

`default_nettype wire

### hw/rtl/sfpc_checker.sv
// ----------------------------------------------------------------------------
// sfpc_checker
// Port-level checks on the framed packet checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [sfpc_pkg::PAYLOAD_W-1:0] i_out_payload,
    input wire logic                           i_out_check_ok,
    input wire logic [sfpc_pkg::CHECK_W-1:0]   i_out_received_check
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // with no result pending, the byte input never stalls
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result slot");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_payload) && $stable(i_out_check_ok)
            && $stable(i_out_received_check))
        else $error("result changed while stalled");

endmodule

bind sync_framed_packet_checker sfpc_checker u_sfpc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_rx.valid),
    .i_in_ready           (i_rx.ready),
    .i_out_valid          (o_res.valid),
    .i_out_ready          (o_res.ready),
    .i_out_payload        (o_res.payload),
    .i_out_check_ok       (o_res.check_ok),
    .i_out_received_check (o_res.received_check)
);

`default_nettype wire
